@@ hw/rtl/tdpt_pkg.sv @@
// Shared types for the trial-division prime test.
// Controller state encoding plus the command and status bundles between
// controller and datapath. No dependencies.
package tdpt_pkg;

  localparam int unsigned CandidateWidth = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_DIVIDE,
    S_EVAL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic next_d;
    logic set_verdict;
    logic verdict;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic below_two;
    logic is_two;
    logic is_even;
    logic div_last;
    logic bound_exceeded;
    logic rem_zero;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/tdpt_ctrl.sv @@
// Controller for the trial-division prime test.
// Sequences classify, per-divisor restoring division and result hand-off.
// Depends on tdpt_pkg.
module tdpt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              candidate_valid,
  output logic              candidate_ready,
  input  tdpt_pkg::status_t status,
  output tdpt_pkg::cmd_t    cmd
);

  tdpt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdpt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tdpt_pkg::S_IDLE: begin
        if (candidate_valid) begin
          state_next = tdpt_pkg::S_CLASSIFY;
        end
      end
      tdpt_pkg::S_CLASSIFY: begin
        if (status.below_two || status.is_two || status.is_even) begin
          state_next = tdpt_pkg::S_FINISH;
        end else begin
          state_next = tdpt_pkg::S_DIVIDE;
        end
      end
      tdpt_pkg::S_DIVIDE: begin
        if (status.div_last) begin
          state_next = tdpt_pkg::S_EVAL;
        end
      end
      tdpt_pkg::S_EVAL: begin
        if (status.bound_exceeded || status.rem_zero) begin
          state_next = tdpt_pkg::S_FINISH;
        end else begin
          state_next = tdpt_pkg::S_DIVIDE;
        end
      end
      tdpt_pkg::S_FINISH: begin
        if (status.out_free) begin
          state_next = tdpt_pkg::S_IDLE;
        end
      end
      default: state_next = tdpt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    candidate_ready = 1'b0;
    case (state)
      tdpt_pkg::S_IDLE: begin
        candidate_ready = 1'b1;
        cmd.load        = candidate_valid;
      end
      tdpt_pkg::S_CLASSIFY: begin
        if (status.below_two || status.is_two || status.is_even) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = status.is_two;
        end else begin
          cmd.div_start = 1'b1;
        end
      end
      tdpt_pkg::S_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      tdpt_pkg::S_EVAL: begin
        if (status.bound_exceeded) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b1;
        end else if (status.rem_zero) begin
          cmd.set_verdict = 1'b1;
          cmd.verdict     = 1'b0;
        end else begin
          cmd.next_d    = 1'b1;
          cmd.div_start = 1'b1;
        end
      end
      tdpt_pkg::S_FINISH: begin
        cmd.emit = status.out_free;
      end
      default: cmd = '0;
    endcase
  end

  // a verdict is only ever taken in a deciding state, and leads to hand-off
  assert property (@(posedge clk) disable iff (rst)
    cmd.set_verdict |=> state == tdpt_pkg::S_FINISH)
    else $error("verdict set without moving to finish");

  // a new division always begins with the divider running next cycle
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> cmd.div_step)
    else $error("division started but not stepped");

  // an emitted result returns the block to accept the next candidate
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> candidate_ready)
    else $error("emit did not return to idle");

endmodule

@@ hw/rtl/tdpt_datapath.sv @@
// Datapath for the trial-division prime test.
// Holds the candidate, odd divisor, a one-bit-per-cycle restoring divider
// and the output register. Depends on tdpt_pkg.
module tdpt_datapath #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [VALUE_WIDTH-1:0] value,
  input  tdpt_pkg::cmd_t         cmd,
  output tdpt_pkg::status_t      status,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic                   is_prime
);

  localparam int unsigned CntW = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0] n;
  logic [VALUE_WIDTH-1:0] d;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] quo;
  logic [CntW-1:0]        cnt;
  logic                   verdict;

  logic [VALUE_WIDTH:0]   shifted;
  logic [VALUE_WIDTH+1:0] diff;

  assign shifted = {rem, quo[VALUE_WIDTH-1]};
  assign diff    = {1'b0, shifted} - {2'b00, d};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= value;
      d <= VALUE_WIDTH'(3);
    end else if (cmd.next_d) begin
      d <= d + VALUE_WIDTH'(2);
    end

    if (cmd.div_start) begin
      rem <= '0;
      quo <= n;
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + CntW'(1);
      if (!diff[VALUE_WIDTH+1]) begin
        rem <= diff[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[VALUE_WIDTH-1:0];
        quo <= {quo[VALUE_WIDTH-2:0], 1'b0};
      end
    end

    if (cmd.set_verdict) begin
      verdict <= cmd.verdict;
    end

    if (cmd.emit) begin
      is_prime <= verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_comb begin
    status.below_two      = (n[VALUE_WIDTH-1:1] == '0);
    status.is_two         = (n == VALUE_WIDTH'(2));
    status.is_even        = !n[0];
    status.div_last       = (cnt == CntW'(VALUE_WIDTH - 1));
    status.bound_exceeded = (d > quo);
    status.rem_zero       = (rem == '0);
    status.out_free       = !result_valid || result_ready;
  end

  // remainder must end below the divisor
  assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && status.div_last) |=> rem < d)
    else $error("divider remainder not below divisor");

  // divisor stays odd through every increment
  assert property (@(posedge clk) disable iff (rst)
    (cmd.load || cmd.next_d) |=> d[0])
    else $error("trial divisor became even");

  // emitted verdict lands in the output register
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> result_valid && is_prime == $past(verdict))
    else $error("result register missed the verdict");

endmodule

@@ hw/rtl/trial_division_prime_test_top.sv @@
// Top level of the trial-division prime test.
// Instantiates tdpt_ctrl and tdpt_datapath; uses tdpt_pkg.
//
// Takes one candidate at a time and answers whether it is prime. Values
// below two and all even values, two included, are settled in the classify
// state without any division. Odd candidates try divisors 3, 5, 7, ... while
// the divisor does not exceed candidate / divisor; each divisor runs through
// the shared restoring divider, which produces one quotient bit per cycle.
// A new candidate is accepted once the previous result has been loaded into
// the output register.
module trial_division_prime_test_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  candidate_valid,
  output logic                                  candidate_ready,
  input  logic [tdpt_pkg::CandidateWidth-1:0]   candidate,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic                                  is_prime
);

  localparam int unsigned CandW = tdpt_pkg::CandidateWidth;

  logic [VALUE_WIDTH-1:0] value;
  tdpt_pkg::cmd_t         cmd;
  tdpt_pkg::status_t      status;

  generate
    if (VALUE_WIDTH > CandW) begin : g_extend
      assign value = {{(VALUE_WIDTH - CandW){1'b0}}, candidate};
    end else if (VALUE_WIDTH == CandW) begin : g_equal
      assign value = candidate;
    end else begin : g_trunc
      assign value = candidate[VALUE_WIDTH-1:0];
    end
  endgenerate

  tdpt_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .candidate_valid (candidate_valid),
    .candidate_ready (candidate_ready),
    .status          (status),
    .cmd             (cmd)
  );

  tdpt_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_prime     (is_prime)
  );

endmodule

@@ tb/sv/primality_checker.sv @@
// Checker for the trial-division prime test: watches both channels, predicts
// each verdict by trial division and compares it with the block's answer.
// Depends on tdpt_pkg for the candidate width.
module primality_checker #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                candidate_valid,
  input  logic                                candidate_ready,
  input  logic [tdpt_pkg::CandidateWidth-1:0] candidate,
  input  logic                                result_valid,
  input  logic                                result_ready,
  input  logic                                is_prime,
  output int                                  mismatches,
  output int                                  verdicts_pending,
  output int                                  verdicts_checked,
  output int                                  primes_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  bit expected_verdicts[$];
  bit next_verdict;

  function automatic bit primality_of(logic [tdpt_pkg::CandidateWidth-1:0] raw);
    longint unsigned n;
    longint unsigned d;
    n = 64'(raw) & ((~64'd0) >> (64 - VALUE_WIDTH));
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if ((n & 1) == 0) return 1'b0;
    // bound as d <= n / d so the square never overflows
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  initial begin
    mismatches       = 0;
    verdicts_pending = 0;
    verdicts_checked = 0;
    primes_seen      = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (candidate_valid && candidate_ready) begin
        expected_verdicts = {expected_verdicts, primality_of(candidate)};
      end
      if (result_valid && result_ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %b with no candidate outstanding", is_prime));
        end else begin
          next_verdict = expected_verdicts.pop_front();
          verdicts_checked++;
          if (is_prime !== next_verdict) begin
            report_mismatch($sformatf("is_prime %b, expected %b", is_prime, next_verdict));
          end else if (next_verdict) begin
            primes_seen++;
          end
        end
      end
    end
    verdicts_pending = expected_verdicts.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for trial_division_prime_test_top: clock, reset, candidate
// stimulus and result back-pressure. Uses tdpt_pkg and primality_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_WIDTH        = 32;
  localparam int          CYCLE_LIMIT        = 8_000_000;
  localparam int          RESULT_HOLD_CYCLES = 400;
  localparam int          SETTLE_CYCLES      = 50;

  logic                                clk             = 1'b0;
  logic                                rst             = 1'b1;
  logic                                candidate_valid = 1'b0;
  logic                                candidate_ready;
  logic [tdpt_pkg::CandidateWidth-1:0] candidate       = '0;
  logic                                result_valid;
  logic                                result_ready    = 1'b0;
  logic                                is_prime;

  int mismatches;
  int verdicts_pending;
  int verdicts_checked;
  int primes_seen;

  int tx_idle_pct    = 18;
  int rx_idle_pct    = 45;
  bit hold_results   = 1'b0;
  bit hold_served    = 1'b0;
  int candidates_sent = 0;
  int cycle_count    = 0;

  trial_division_prime_test_top #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .candidate_valid(candidate_valid),
    .candidate_ready(candidate_ready),
    .candidate      (candidate),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .is_prime       (is_prime)
  );

  primality_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) checker_inst (
    .clk             (clk),
    .rst             (rst),
    .candidate_valid (candidate_valid),
    .candidate_ready (candidate_ready),
    .candidate       (candidate),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .is_prime        (is_prime),
    .mismatches      (mismatches),
    .verdicts_pending(verdicts_pending),
    .verdicts_checked(verdicts_checked),
    .primes_seen     (primes_seen)
  );

  always #6 clk = ~clk;

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
             verdicts_pending);
    $display("trial_division_prime_test_top regression: fail");
    $finish;
  end

  // result side: random stalls, plus one long hold while candidates keep coming
  initial begin
    int hold_cycles;
    forever begin
      @(negedge clk);
      if (hold_results && !hold_served) begin
        result_ready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < RESULT_HOLD_CYCLES; hold_cycles++) begin
          @(negedge clk);
        end
        hold_served = 1'b1;
      end else begin
        result_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic offer_candidate(input logic [31:0] value);
    @(negedge clk);
    if ($urandom_range(99) < tx_idle_pct) begin
      candidate_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    candidate       <= value;
    candidate_valid <= 1'b1;
    do @(posedge clk); while (!candidate_ready);
    candidates_sent++;
  endtask

  task automatic wait_for_verdicts();
    @(negedge clk);
    candidate_valid <= 1'b0;
    while (verdicts_pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_candidate();
    int unsigned kind;
    int unsigned bits;
    int unsigned factor;
    int unsigned q;
    kind = $urandom_range(99);
    if (kind < 40) begin
      bits = $urandom_range(14, 2);
      return $urandom & ((32'd1 << bits) - 1);
    end else if (kind < 55) begin
      bits = $urandom_range(20, 15);
      return $urandom & ((32'd1 << bits) - 1);
    end else if (kind < 75) begin
      return $urandom & ~32'd1;
    end else if (kind < 90) begin
      // full-width multiple of a small odd prime: cheap to reject
      case ($urandom_range(4))
        0:       factor = 3;
        1:       factor = 5;
        2:       factor = 7;
        3:       factor = 11;
        default: factor = 13;
      endcase
      return factor * $urandom_range(32'hFFFF_FFFF / factor);
    end else begin
      // squares and twin products sit right on the divisor bound
      q = 2 * $urandom_range(127, 1) + 1;
      return $urandom_range(1) ? q * q : q * (q + 2);
    end
  endfunction

  task automatic run_random(input int count);
    repeat (count) offer_candidate(pick_candidate());
  endtask

  initial begin
    logic [31:0] directed_values[$];
    int          directed_count;
    directed_values = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49,
      32'd97, 32'd121, 32'd255, 32'd257, 32'd65536, 32'd65537, 32'd1000003,
      32'h5555_5555, 32'h8000_0000, 32'd4294836225, 32'hFFFF_FFFE,
      32'hFFFF_FFFF, 32'hFFFF_FFFB
    };
    directed_count = directed_values.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_values[i]) offer_candidate(directed_values[i]);
    run_random(25);
    wait_for_verdicts();

    tx_idle_pct = 45;
    rx_idle_pct = 18;
    run_random(25);
    wait_for_verdicts();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(12);
    hold_results = 1'b1;
    repeat (10) offer_candidate($urandom_range(200, 2));
    run_random(5);
    wait_for_verdicts();

    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("sent %0d candidates (%0d directed, rest random), %0d verdicts checked, %0d prime",
             candidates_sent, directed_count, verdicts_checked, primes_seen);
    $display("covered zero, one, two, even values, squares, top of range and a long result hold");
    if (mismatches == 0 && verdicts_pending == 0) begin
      $display("trial_division_prime_test_top regression: pass");
    end else begin
      $display("trial_division_prime_test_top regression: fail");
    end
    $finish;
  end

endmodule
